// ===== hw/rtl/dau_pkg.sv =====
// Shared widths, constants, sideband type and arithmetic helpers for the dihedral angle unit.
package dau_pkg;

	// Default top-level parameter values.
	localparam int COORD_WIDTH_DEF = 24;
	localparam int ANGLE_WIDTH_DEF = 16;

	// Scaled operands stay below 2^30 in magnitude, so they fit 31 signed bits.
	localparam int VW = 31;
	localparam int PW = 2 * VW;
	localparam int SSW = 62;
	localparam int SQ_CELLS = SSW / 2;
	localparam int XW = 36;
	localparam int ZW = 24;
	localparam int ZFRAC = 20;
	localparam int CORDIC_N = 20;
	localparam int NORM_TOP = 30;

	localparam logic signed [ZW-1:0] PI_Q = 24'sd3294199;
	localparam logic signed [ZW-1:0] HALF_PI_Q = 24'sd1647099;

	// Cross product index helpers: component j uses a[NX1]*b[NX2] - a[NX2]*b[NX1].
	localparam int NX1 [3] = '{1, 2, 0};
	localparam int NX2 [3] = '{2, 0, 1};

	// Sideband that travels with each beat through the back half of the pipeline.
	typedef struct packed {
		logic valid;
		logic illegal;
		logic neg;
		logic fix;
		logic fixpi;
		logic signed [VW-1:0] c;
	} side_t;

	// Arctangent of 2^-i in Q20.
	function automatic logic signed [ZW-1:0] atan_q(input int i);
		logic signed [ZW-1:0] t;
		begin
			case (i)
				0: t = 24'sd823550;
				1: t = 24'sd486170;
				2: t = 24'sd256879;
				3: t = 24'sd130396;
				4: t = 24'sd65451;
				5: t = 24'sd32757;
				6: t = 24'sd16383;
				default: t = ZW'(64'sd1 <<< (ZFRAC - i));
			endcase
			return t;
		end
	endfunction

	// Magnitude of a signed word.
	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	// Number of significant bits of an unsigned word.
	function automatic logic [6:0] bitlen64(input logic [63:0] v);
		logic [6:0] bl;
		begin
			bl = '0;
			for (int i = 0; i < 64; i++) begin
				if (v[i]) bl = 7'(i + 1);
			end
			return bl;
		end
	endfunction

	// Least right shift that brings every magnitude below 2^30.
	function automatic logic [5:0] scale_amt(input logic [63:0] ormag);
		logic [6:0] bl;
		begin
			bl = bitlen64(ormag);
			return (bl > 7'd30) ? 6'(bl - 7'd30) : 6'd0;
		end
	endfunction

	// Right shift that truncates toward zero.
	function automatic logic signed [63:0] shr_tz64(input logic signed [63:0] v,
		input logic [5:0] k);
		logic [63:0] m;
		begin
			m = mag64(v) >> k;
			return v[63] ? -$signed(m) : $signed(m);
		end
	endfunction

endpackage

// ===== hw/rtl/dihedral_angle_unit.sv =====
// Dihedral angle unit top level: vector front end, square root chain, CORDIC chain, output.
// Each beat passes the front, root, normalization, CORDIC and output registers in order.
// Throughput: one beat per cycle; busy is always low.
// The rate is set by a fully pipelined chain of 31 root cells and 20 CORDIC cells.
// Reset clears valid flags, sidebands and output flags; no beat is in flight after reset.
// The receiver cannot stall, so no result is ever held back.
module dihedral_angle_unit #(
	parameter int COORD_WIDTH = dau_pkg::COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH = dau_pkg::ANGLE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] p1_x,
	input  logic signed [COORD_WIDTH-1:0] p1_y,
	input  logic signed [COORD_WIDTH-1:0] p1_z,
	input  logic signed [COORD_WIDTH-1:0] p2_x,
	input  logic signed [COORD_WIDTH-1:0] p2_y,
	input  logic signed [COORD_WIDTH-1:0] p2_z,
	input  logic signed [COORD_WIDTH-1:0] p3_x,
	input  logic signed [COORD_WIDTH-1:0] p3_y,
	input  logic signed [COORD_WIDTH-1:0] p3_z,
	input  logic signed [COORD_WIDTH-1:0] p4_x,
	input  logic signed [COORD_WIDTH-1:0] p4_y,
	input  logic signed [COORD_WIDTH-1:0] p4_z,
	output logic                          done,
	output logic signed [ANGLE_WIDTH-1:0] torsion,
	output logic                          illegal
);
	import dau_pkg::*;

	localparam int AFRAC = ANGLE_WIDTH - 3;
	localparam int SHR = (ZFRAC > AFRAC) ? (ZFRAC - AFRAC) : 0;
	localparam int SHL = (AFRAC > ZFRAC) ? (AFRAC - ZFRAC) : 0;
	localparam int RW = ZW + 2;
	localparam logic signed [RW-1:0] RND = (SHR > 0) ? RW'(64'sd1 <<< (SHR - 1)) : '0;
	localparam logic signed [ANGLE_WIDTH-1:0] PI_OUT =
		ANGLE_WIDTH'(((RW'(PI_Q) + RND) >>> SHR) <<< SHL);

	logic signed [COORD_WIDTH-1:0] pts [12];
	logic [SSW-1:0] ss_f;
	side_t          side_f;

	assign busy = 1'b0;

	always_comb begin
		pts[0]  = p1_x;
		pts[1]  = p1_y;
		pts[2]  = p1_z;
		pts[3]  = p2_x;
		pts[4]  = p2_y;
		pts[5]  = p2_z;
		pts[6]  = p3_x;
		pts[7]  = p3_y;
		pts[8]  = p3_z;
		pts[9]  = p4_x;
		pts[10] = p4_y;
		pts[11] = p4_z;
	end

	dau_front #(.CW(COORD_WIDTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start & ~busy),
		.p        (pts),
		.ss       (ss_f),
		.side     (side_f)
	);

	// Square root chain, one root bit per cell.
	side_t          sq_side [SQ_CELLS+1];
	logic [VW+1:0]  sq_rem  [SQ_CELLS+1];
	logic [VW-1:0]  sq_root [SQ_CELLS+1];
	logic [SSW-1:0] sq_v    [SQ_CELLS+1];

	assign sq_side[0] = side_f;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_v[0]    = ss_f;

	for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sq
		dau_isqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.side_i (sq_side[i]),
			.rem_i  (sq_rem[i]),
			.root_i (sq_root[i]),
			.v_i    (sq_v[i]),
			.side_q (sq_side[i+1]),
			.rem_q  (sq_rem[i+1]),
			.root_q (sq_root[i+1]),
			.v_q    (sq_v[i+1])
		);
	end

	// Normalization: find the doubling count, then shift and pre-rotate.
	logic [VW-1:0]   s_top;
	logic [VW:0]     cmag;
	logic [VW:0]     mmax;
	logic [6:0]      mbl;
	side_t           side_n;
	side_t           side_s1;
	logic [VW-1:0]   s_s1;
	logic [5:0]      d_s1;
	side_t           side_s2;
	logic signed [XW-1:0] x_s2;
	logic signed [XW-1:0] y_s2;
	logic signed [ZW-1:0] z_s2;
	logic signed [XW-1:0] cs;
	logic signed [XW-1:0] sn;

	always_comb begin
		s_top        = sq_root[SQ_CELLS];
		cmag         = (VW+1)'(mag64(64'(sq_side[SQ_CELLS].c)));
		mmax         = (cmag > (VW+1)'(s_top)) ? cmag : (VW+1)'(s_top);
		mbl          = bitlen64(64'(mmax));
		side_n       = sq_side[SQ_CELLS];
		side_n.fix   = (s_top == '0);
		side_n.fixpi = sq_side[SQ_CELLS].c[VW-1];
		cs           = XW'(side_s1.c) <<< d_s1;
		sn           = XW'(s_s1) << d_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
		end else begin
			side_s1 <= side_n;
			side_s2 <= side_s1;
		end
	end

	always_ff @(posedge clk) begin
		s_s1 <= s_top;
		d_s1 <= (mbl < 7'(NORM_TOP)) ? 6'(7'(NORM_TOP) - mbl) : 6'd0;
		if (side_s1.c[VW-1]) begin
			x_s2 <= sn;
			y_s2 <= -cs;
			z_s2 <= HALF_PI_Q;
		end else begin
			x_s2 <= cs;
			y_s2 <= sn;
			z_s2 <= '0;
		end
	end

	// CORDIC vectoring chain.
	side_t                cr_side [CORDIC_N+1];
	logic signed [XW-1:0] cr_x    [CORDIC_N+1];
	logic signed [XW-1:0] cr_y    [CORDIC_N+1];
	logic signed [ZW-1:0] cr_z    [CORDIC_N+1];

	assign cr_side[0] = side_s2;
	assign cr_x[0]    = x_s2;
	assign cr_y[0]    = y_s2;
	assign cr_z[0]    = z_s2;

	for (genvar i = 0; i < CORDIC_N; i++) begin : g_cr
		dau_cordic_cell #(.IDX(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.side_i (cr_side[i]),
			.x_i    (cr_x[i]),
			.y_i    (cr_y[i]),
			.z_i    (cr_z[i]),
			.side_q (cr_side[i+1]),
			.x_q    (cr_x[i+1]),
			.y_q    (cr_y[i+1]),
			.z_q    (cr_z[i+1])
		);
	end

	// Clamp, round to the output format and apply the sign.
	side_t                side_e;
	logic signed [ZW-1:0] ze;
	logic signed [ZW-1:0] zc;
	logic signed [RW-1:0] zr;
	logic signed [ANGLE_WIDTH-1:0] ang;

	always_comb begin
		side_e = cr_side[CORDIC_N];
		ze     = cr_z[CORDIC_N];
		if (side_e.fix) begin
			zc = side_e.fixpi ? PI_Q : '0;
		end else if (ze < 0) begin
			zc = '0;
		end else if (ze > PI_Q) begin
			zc = PI_Q;
		end else begin
			zc = ze;
		end
		zr  = ((RW'(zc) + RND) >>> SHR) <<< SHL;
		ang = side_e.neg ? -ANGLE_WIDTH'(zr) : ANGLE_WIDTH'(zr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done    <= 1'b0;
			illegal <= 1'b0;
		end else begin
			done    <= side_e.valid;
			illegal <= side_e.valid & side_e.illegal;
		end
	end

	always_ff @(posedge clk) begin
		torsion <= side_e.illegal ? '0 : ang;
	end

	// An illegal beat always reports a zero angle.
	a_illegal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && illegal |-> torsion == '0)
		else $error("illegal result with nonzero angle");

	// The angle never leaves the range of plus or minus pi.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (torsion <= PI_OUT) && (torsion >= -PI_OUT))
		else $error("angle outside plus or minus pi");

	// The illegal flag is only shown together with the strobe.
	a_illegal_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		illegal |-> done)
		else $error("illegal flag without result strobe");

endmodule

// ===== hw/rtl/dau_isqrt_cell.sv =====
// One digit cell of the pipelined integer square root chain.
module dau_isqrt_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dau_pkg::side_t             side_i,
	input  logic [dau_pkg::VW+1:0]     rem_i,
	input  logic [dau_pkg::VW-1:0]     root_i,
	input  logic [dau_pkg::SSW-1:0]    v_i,
	output dau_pkg::side_t             side_q,
	output logic [dau_pkg::VW+1:0]     rem_q,
	output logic [dau_pkg::VW-1:0]     root_q,
	output logic [dau_pkg::SSW-1:0]    v_q
);
	import dau_pkg::*;

	logic [VW+3:0] rem_n;
	logic [VW+3:0] trial;
	logic          ge;

	// Bring down the next two radicand bits and try the next root bit.
	always_comb begin
		rem_n = {rem_i, v_i[SSW-1:SSW-2]};
		trial = (VW+4)'({root_i, 2'b01});
		ge    = (rem_n >= trial);
	end

	// Sideband carries the beat's valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
		end else begin
			side_q <= side_i;
		end
	end

	// Remainder, partial root and remaining radicand bits move on.
	always_ff @(posedge clk) begin
		rem_q  <= ge ? (VW+2)'(rem_n - trial) : (VW+2)'(rem_n);
		root_q <= {root_i[VW-2:0], ge};
		v_q    <= v_i << 2;
	end

endmodule

// ===== hw/rtl/dau_cordic_cell.sv =====
// One vectoring micro-rotation cell of the angle chain.
module dau_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dau_pkg::side_t                side_i,
	input  logic signed [dau_pkg::XW-1:0] x_i,
	input  logic signed [dau_pkg::XW-1:0] y_i,
	input  logic signed [dau_pkg::ZW-1:0] z_i,
	output dau_pkg::side_t                side_q,
	output logic signed [dau_pkg::XW-1:0] x_q,
	output logic signed [dau_pkg::XW-1:0] y_q,
	output logic signed [dau_pkg::ZW-1:0] z_q
);
	import dau_pkg::*;

	localparam logic signed [ZW-1:0] ANG = atan_q(IDX);
	localparam logic [5:0] SH = 6'(IDX);

	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;

	// Shifted copies truncate toward zero.
	always_comb begin
		xs = XW'(shr_tz64(64'(x_i), SH));
		ys = XW'(shr_tz64(64'(y_i), SH));
	end

	// Sideband carries the beat's valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
		end else begin
			side_q <= side_i;
		end
	end

	// Rotate toward the x axis and track the angle.
	always_ff @(posedge clk) begin
		if (y_i > 0) begin
			x_q <= x_i + ys;
			y_q <= y_i - xs;
			z_q <= z_i + ANG;
		end else begin
			x_q <= x_i - ys;
			y_q <= y_i + xs;
			z_q <= z_i - ANG;
		end
	end

endmodule

// ===== hw/rtl/dau_front.sv =====
// Vector front end: bond vectors, plane normals, their cross and dot products, and scaling.
module dau_front #(
	parameter int CW = dau_pkg::COORD_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic signed [CW-1:0]    p [12],
	output logic [dau_pkg::SSW-1:0] ss,
	output dau_pkg::side_t          side
);
	import dau_pkg::*;

	localparam int BW = CW + 1;
	localparam int NST = 10;

	typedef logic signed [VW-1:0] v_t;
	typedef logic signed [PW-1:0] pr_t;
	typedef logic signed [63:0]   w_t;

	logic [NST-1:0] vld_q;

	logic signed [BW-1:0] b_s1 [9];
	v_t  b_s2 [9];
	pr_t pr_s3 [12];
	v_t  b23_s3 [3];
	w_t  n_s4 [6];
	v_t  b23_s4 [3];
	v_t  n_s5 [6];
	v_t  b23_s5 [3];
	logic ill_s5;
	pr_t pr_s6 [9];
	v_t  b23_s6 [3];
	logic ill_s6;
	w_t  cd_s7 [4];
	v_t  b23_s7 [3];
	logic ill_s7;
	v_t  cd_s8 [4];
	v_t  b23_s8 [3];
	logic ill_s8;
	pr_t sq_s9 [3];
	pr_t dp_s9 [3];
	v_t  c_s9;
	logic ill_s9;
	logic [SSW-1:0] ss_s10;
	logic neg_s10;
	v_t  c_s10;
	logic ill_s10;

	logic [5:0] kb;
	logic [5:0] kn1;
	logic [5:0] kn2;
	logic [5:0] kc;
	logic       zero1;
	logic       zero2;
	w_t         ssum;
	w_t         dsum;

	// Shift amounts and zero tests for the scaling stages.
	always_comb begin
		logic [63:0] ob;
		logic [63:0] o1;
		logic [63:0] o2;
		logic [63:0] oc;
		ob = '0;
		o1 = '0;
		o2 = '0;
		oc = '0;
		for (int i = 0; i < 9; i++) ob = ob | mag64(64'(b_s1[i]));
		for (int j = 0; j < 3; j++) begin
			o1 = o1 | mag64(n_s4[j]);
			o2 = o2 | mag64(n_s4[j+3]);
		end
		for (int j = 0; j < 4; j++) oc = oc | mag64(cd_s7[j]);
		kb    = scale_amt(ob);
		kn1   = scale_amt(o1);
		kn2   = scale_amt(o2);
		kc    = scale_amt(oc);
		zero1 = (o1 == '0);
		zero2 = (o2 == '0);
		ssum  = 64'(sq_s9[0]) + 64'(sq_s9[1]) + 64'(sq_s9[2]);
		dsum  = 64'(dp_s9[0]) + 64'(dp_s9[1]) + 64'(dp_s9[2]);
	end

	// Beat valid flags through the ten front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[NST-2:0], in_valid};
		end
	end

	// Datapath stages.
	always_ff @(posedge clk) begin
		// Bond vectors.
		for (int i = 0; i < 9; i++) b_s1[i] <= BW'(p[i+3]) - BW'(p[i]);
		// Common scaling of the bond vectors.
		for (int i = 0; i < 9; i++) b_s2[i] <= VW'(shr_tz64(64'(b_s1[i]), kb));
		// Partial products of both normals.
		for (int j = 0; j < 3; j++) begin
			pr_s3[2*j]     <= b_s2[NX1[j]] * b_s2[3+NX2[j]];
			pr_s3[2*j+1]   <= b_s2[NX2[j]] * b_s2[3+NX1[j]];
			pr_s3[6+2*j]   <= b_s2[3+NX1[j]] * b_s2[6+NX2[j]];
			pr_s3[6+2*j+1] <= b_s2[3+NX2[j]] * b_s2[6+NX1[j]];
			b23_s3[j]      <= b_s2[3+j];
		end
		// Normals.
		for (int j = 0; j < 6; j++) n_s4[j] <= 64'(pr_s3[2*j]) - 64'(pr_s3[2*j+1]);
		b23_s4 <= b23_s3;
		// Separate scaling of each normal; a zero normal marks the beat illegal.
		for (int j = 0; j < 3; j++) begin
			n_s5[j]   <= VW'(shr_tz64(n_s4[j], kn1));
			n_s5[j+3] <= VW'(shr_tz64(n_s4[j+3], kn2));
		end
		ill_s5 <= zero1 | zero2;
		b23_s5 <= b23_s4;
		// Partial products of the normals' cross and dot products.
		for (int j = 0; j < 3; j++) begin
			pr_s6[2*j]   <= n_s5[NX1[j]] * n_s5[3+NX2[j]];
			pr_s6[2*j+1] <= n_s5[NX2[j]] * n_s5[3+NX1[j]];
			pr_s6[6+j]   <= n_s5[j] * n_s5[3+j];
		end
		ill_s6 <= ill_s5;
		b23_s6 <= b23_s5;
		// Cross product components and dot product.
		for (int j = 0; j < 3; j++) cd_s7[j] <= 64'(pr_s6[2*j]) - 64'(pr_s6[2*j+1]);
		cd_s7[3] <= 64'(pr_s6[6]) + 64'(pr_s6[7]) + 64'(pr_s6[8]);
		ill_s7 <= ill_s6;
		b23_s7 <= b23_s6;
		// Common scaling of the four values.
		for (int j = 0; j < 4; j++) cd_s8[j] <= VW'(shr_tz64(cd_s7[j], kc));
		ill_s8 <= ill_s7;
		b23_s8 <= b23_s7;
		// Squares for the sine and products for the direction.
		for (int j = 0; j < 3; j++) begin
			sq_s9[j] <= cd_s8[j] * cd_s8[j];
			dp_s9[j] <= cd_s8[j] * b23_s8[j];
		end
		c_s9   <= cd_s8[3];
		ill_s9 <= ill_s8;
		// Sum of squares and direction sign.
		ss_s10  <= ssum[SSW-1:0];
		neg_s10 <= dsum[63];
		c_s10   <= c_s9;
		ill_s10 <= ill_s9;
	end

	assign ss = ss_s10;

	always_comb begin
		side         = '0;
		side.valid   = vld_q[NST-1];
		side.illegal = ill_s10;
		side.neg     = neg_s10;
		side.c       = c_s10;
	end

endmodule

// ===== tb/sv/dihedral_angle_unit_tb.sv =====
// Self-checking testbench for the dihedral angle unit: directed and random atom quadruples.
`timescale 1ns / 100ps

module dihedral_angle_unit_tb;

	localparam int CW = dau_pkg::COORD_WIDTH_DEF;
	localparam int AW = dau_pkg::ANGLE_WIDTH_DEF;
	localparam int LATENCY = 64;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 500;
	localparam int FIFO_DEPTH = 1024;

	// Idle phases for the sender.
	typedef enum int {IDLE_NONE, IDLE_HALF, IDLE_BOTH} idle_mode_t;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		logic signed [AW-1:0] torsion;
		logic illegal;
	} angle_res_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	coord_t p1_x, p1_y, p1_z, p2_x, p2_y, p2_z;
	coord_t p3_x, p3_y, p3_z, p4_x, p4_y, p4_z;
	logic done;
	logic signed [AW-1:0] torsion;
	logic illegal;

	// Expected results in send order, as a ring with write and read counts.
	angle_res_t want_fifo [FIFO_DEPTH];
	int wr_ptr;
	int rd_ptr;
	int cycle_count;
	int error_count;
	int beats_sent;
	int results_seen;
	int illegal_seen;
	idle_mode_t idle_mode;

	dihedral_angle_unit i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.p1_x(p1_x), .p1_y(p1_y), .p1_z(p1_z),
		.p2_x(p2_x), .p2_y(p2_y), .p2_z(p2_z),
		.p3_x(p3_x), .p3_y(p3_y), .p3_z(p3_z),
		.p4_x(p4_x), .p4_y(p4_y), .p4_z(p4_z),
		.done(done), .torsion(torsion), .illegal(illegal)
	);

	// Clock.
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Cycle counter with a timeout.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("dihedral_angle_unit_tb: errors");
			$finish;
		end
	end

	function automatic longint abs64(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint trunc_shift(input longint v, input int k);
		if (k >= 63) return 0;
		return v < 0 ? -((-v) >>> k) : (v >>> k);
	endfunction

	// Bring a set of values below 2^30 by one common truncating shift.
	function automatic void fit30(ref longint v[], input int n);
		longint m;
		int k;
		m = 0;
		k = 0;
		for (int i = 0; i < n; i++) if (abs64(v[i]) > m) m = abs64(v[i]);
		while (k < 62 && (m >>> k) >= (64'sd1 <<< 30)) k++;
		for (int i = 0; i < n; i++) v[i] = trunc_shift(v[i], k);
	endfunction

	function automatic longint int_sqrt(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	// Torsion angle of four atoms, in the block's output format.
	function automatic angle_res_t torsion_of(input coord_t p[12]);
		longint bv[], n1[], n2[], cd[];
		longint dir, cs, sn, x, y, z, t, xs, ys, mx, r;
		longint atan_q20[7];
		angle_res_t res;
		atan_q20 = '{823550, 486170, 256879, 130396, 65451, 32757, 16383};
		bv = new[9];
		n1 = new[3];
		n2 = new[3];
		cd = new[4];
		for (int i = 0; i < 9; i++) bv[i] = longint'(p[i+3]) - longint'(p[i]);
		fit30(bv, 9);
		n1[0] = bv[1]*bv[5] - bv[2]*bv[4];
		n1[1] = bv[2]*bv[3] - bv[0]*bv[5];
		n1[2] = bv[0]*bv[4] - bv[1]*bv[3];
		n2[0] = bv[4]*bv[8] - bv[5]*bv[7];
		n2[1] = bv[5]*bv[6] - bv[3]*bv[8];
		n2[2] = bv[3]*bv[7] - bv[4]*bv[6];
		res.torsion = '0;
		res.illegal = 1'b1;
		// A zero normal means collinear atoms.
		if ((n1[0] == 0 && n1[1] == 0 && n1[2] == 0) ||
			(n2[0] == 0 && n2[1] == 0 && n2[2] == 0)) begin
			return res;
		end
		fit30(n1, 3);
		fit30(n2, 3);
		cd[0] = n1[1]*n2[2] - n1[2]*n2[1];
		cd[1] = n1[2]*n2[0] - n1[0]*n2[2];
		cd[2] = n1[0]*n2[1] - n1[1]*n2[0];
		cd[3] = n1[0]*n2[0] + n1[1]*n2[1] + n1[2]*n2[2];
		fit30(cd, 4);
		dir = cd[0]*bv[3] + cd[1]*bv[4] + cd[2]*bv[5];
		sn = int_sqrt(longint'(cd[0]*cd[0] + cd[1]*cd[1] + cd[2]*cd[2]));
		cs = cd[3];
		if (sn == 0) begin
			z = (cs < 0) ? 3294199 : 0;
		end else begin
			// Normalize, fold into the right half plane, then CORDIC vectoring.
			mx = abs64(cs) > sn ? abs64(cs) : sn;
			while (mx < (64'sd1 <<< 29)) begin
				cs *= 2;
				sn *= 2;
				mx *= 2;
			end
			x = cs;
			y = sn;
			z = 0;
			if (x < 0) begin
				t = y;
				y = -x;
				x = t;
				z = 1647099;
			end
			for (int i = 0; i < 20; i++) begin
				t = (i < 7) ? atan_q20[i] : (64'sd1 <<< (20 - i));
				xs = trunc_shift(x, i);
				ys = trunc_shift(y, i);
				if (y > 0) begin
					x += ys;
					y -= xs;
					z += t;
				end else begin
					x -= ys;
					y += xs;
					z -= t;
				end
			end
			if (z < 0) z = 0;
			if (z > 3294199) z = 3294199;
		end
		r = (z + (64'sd1 <<< (20 - (AW - 3) - 1))) >>> (20 - (AW - 3));
		if (dir < 0) r = -r;
		res.torsion = AW'(r);
		res.illegal = 1'b0;
		return res;
	endfunction

	// Send one beat of four atoms and queue its expected angle.
	task automatic send_atoms(input coord_t p[12]);
		while ((idle_mode == IDLE_HALF && $urandom_range(99) < 51) ||
			(idle_mode == IDLE_BOTH && $urandom_range(99) < 37)) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		{p1_x, p1_y, p1_z, p2_x, p2_y, p2_z} <= {p[0], p[1], p[2], p[3], p[4], p[5]};
		{p3_x, p3_y, p3_z, p4_x, p4_y, p4_z} <= {p[6], p[7], p[8], p[9], p[10], p[11]};
		@(posedge clk);
		while (busy) @(posedge clk);
		want_fifo[wr_ptr % FIFO_DEPTH] = torsion_of(p);
		wr_ptr++;
		beats_sent++;
	endtask

	// Check each result strobe against the oldest expectation.
	always @(posedge clk) begin
		angle_res_t want;
		if (arst_n && done) begin
			results_seen++;
			if (illegal) illegal_seen++;
			if (wr_ptr == rd_ptr) begin
				$error("unexpected result: torsion %0d illegal %0b", torsion, illegal);
				error_count++;
			end else begin
				want = want_fifo[rd_ptr % FIFO_DEPTH];
				rd_ptr++;
				if (torsion !== want.torsion) begin
					$error("torsion: expected %0d, got %0d", want.torsion, torsion);
					error_count++;
				end
				if (illegal !== want.illegal) begin
					$error("illegal: expected %0b, got %0b", want.illegal, illegal);
					error_count++;
				end
			end
		end
	end

	function automatic coord_t rand_coord(input int span);
		int unsigned sel;
		sel = $urandom_range(9);
		if (sel == 0) return coord_t'($urandom);
		if (sel == 1) return ($urandom_range(1) == 0) ? coord_t'(-8388608) : coord_t'(8388607);
		return coord_t'($signed($urandom_range(2 * span)) - span);
	endfunction

	// Directed cases: extremes, collinear atoms, planar cis and trans, signs.
	task automatic test_directed();
		coord_t p[12];
		p = '{0, 0, 0, 256, 0, 0, 256, 256, 0, 512, 256, 0};
		send_atoms(p);
		p = '{0, 256, 0, 0, 0, 0, 256, 0, 0, 256, 256, 0};
		send_atoms(p);
		p = '{0, 256, 0, 0, 0, 0, 256, 0, 0, 256, -256, 0};
		send_atoms(p);
		p = '{0, 256, 0, 0, 0, 0, 256, 0, 0, 256, 0, 256};
		send_atoms(p);
		p = '{0, 256, 0, 0, 0, 0, 256, 0, 0, 256, 0, -256};
		send_atoms(p);
		p = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
		send_atoms(p);
		p = '{1, 2, 3, 1, 2, 3, 7, 8, 9, -4, 5, 6};
		send_atoms(p);
		p = '{-8388608, -8388608, -8388608, 8388607, -8388608, -8388608,
			8388607, 8388607, -8388608, 8388607, 8388607, 8388607};
		send_atoms(p);
		p = '{8388607, 8388607, 8388607, -8388608, 8388607, 8388607,
			-8388608, -8388608, 8388607, -8388608, -8388608, -8388608};
		send_atoms(p);
		p = '{-8388608, 0, 0, 8388607, 0, 0, 8388607, 8388607, 0, -8388608, 8388607, 1};
		send_atoms(p);
		p = '{0, 1, 0, 0, 0, 0, 1, 0, 0, 1, -1, 0};
		send_atoms(p);
		p = '{0, 1, 0, 0, 0, 0, 1, 0, 0, 1, 1, -1};
		send_atoms(p);
		p = '{0, 0, 0, 5, 5, 5, 10, 10, 10, 3, 4, 8};
		send_atoms(p);
		start <= 1'b0;
	endtask

	// Random quadruples with mixed coordinate spans and some collinear sets.
	task automatic test_random(input idle_mode_t mode, input int n);
		coord_t p[12];
		int span;
		idle_mode = mode;
		for (int k = 0; k < n; k++) begin
			span = ($urandom_range(3) == 0) ? 8388607 : (1 << $urandom_range(4, 20));
			foreach (p[i]) p[i] = rand_coord(span);
			if ($urandom_range(19) == 0) begin
				for (int i = 0; i < 3; i++) p[6+i] = coord_t'(2 * p[3+i] - p[i]);
			end
			send_atoms(p);
		end
		start <= 1'b0;
	endtask

	initial begin
		int drain;
		start = 1'b0;
		{p1_x, p1_y, p1_z, p2_x, p2_y, p2_z} = '0;
		{p3_x, p3_y, p3_z, p4_x, p4_y, p4_z} = '0;
		wr_ptr = 0;
		rd_ptr = 0;
		cycle_count = 0;
		error_count = 0;
		beats_sent = 0;
		results_seen = 0;
		illegal_seen = 0;
		idle_mode = IDLE_NONE;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(IDLE_NONE, RANDOM_ITEMS / 4);
		test_random(IDLE_HALF, RANDOM_ITEMS / 4);
		test_random(IDLE_HALF, RANDOM_ITEMS / 4);
		test_random(IDLE_BOTH, RANDOM_ITEMS / 4);

		// Drain the pipeline, then allow stray strobes to show up.
		while (wr_ptr != rd_ptr) @(posedge clk);
		for (drain = 0; drain < 2 * LATENCY; drain++) @(posedge clk);

		$display("Sent %0d beats; checked %0d angles, %0d flagged collinear.",
			beats_sent, results_seen, illegal_seen);
		if (error_count == 0 && wr_ptr == rd_ptr) begin
			$display("dihedral_angle_unit_tb: clean");
		end else begin
			$display("dihedral_angle_unit_tb: errors");
		end
		$finish;
	end

endmodule
